// File: rtl/core/ebf_pkg.sv
// ----------------------------------------------------------------------------
// ebf_pkg
// Shared constants, coefficient table and controller/datapath interface types
// for the ECG baseline removal and FIR low-pass filter.
// ----------------------------------------------------------------------------
package ebf_pkg;

  // sizes
  localparam int CHANNELS   = 7;
  localparam int WINDOW_LEN = 256;
  localparam int TAPS       = 23;
  localparam int LONG_LEN   = 23;
  localparam int SHORT_LEN  = 5;

  // field widths
  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 24;
  localparam int OUT_W    = 32;
  localparam int REG_W    = 16;
  localparam int CFG_IW   = 2;

  // derived widths
  localparam int CH_IW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W      = $clog2(WINDOW_LEN);
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int RING_DEPTH = CHANNELS * WINDOW_LEN;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int TAP_DEPTH  = CHANNELS * TAPS;
  localparam int TAP_AW     = $clog2(TAP_DEPTH);
  localparam int HEAD_W     = $clog2(TAPS);
  localparam int TCNT_W     = $clog2(TAPS + 1);
  localparam int IDX_W      = $clog2(TAPS + 2);
  localparam int AGE_W      = IDX_W + 1;
  localparam int SUM_W      = 32;
  localparam int COEF_W     = 11;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int DIV_W      = 36;
  localparam int DCNT_W     = $clog2(DIV_W + 1);

  // saturation limits
  localparam int HP_MAX = 32767;
  localparam int HP_MIN = -32768;
  localparam int LP_MAX = 2147483647;
  localparam int LP_MIN = -2147483648;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_HP_EN     = 2'd0;
  localparam logic [CFG_IW-1:0] REG_LP_MODE   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_LONG_DIV  = 2'd2;
  localparam logic [CFG_IW-1:0] REG_SHORT_DIV = 2'd3;

  // low-pass modes
  localparam logic [1:0] LP_BYPASS = 2'd0;
  localparam logic [1:0] LP_LONG   = 2'd1;
  localparam logic [1:0] LP_SHORT  = 2'd2;

  localparam logic signed [COEF_W-1:0] LONG_COEF [LONG_LEN] = '{
    11'sd21, -11'sd52, -11'sd26, 11'sd10, 11'sd39, 11'sd25, -11'sd33, -11'sd75,
    -11'sd28, 11'sd120, 11'sd288, 11'sd363, 11'sd288, 11'sd120, -11'sd28,
    -11'sd75, -11'sd33, 11'sd25, 11'sd39, 11'sd10, -11'sd26, -11'sd52, 11'sd21
  };

  // coefficient of one tap, long filter or five tap boxcar
  function automatic logic signed [COEF_W-1:0] tap_coef(input logic [IDX_W-1:0] idx,
                                                        input logic long_sel);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (long_sel) begin
      if (32'(idx) < LONG_LEN) c = LONG_COEF[idx];
    end else begin
      if (32'(idx) < SHORT_LEN) c = 11'sd1;
    end
    return c;
  endfunction

  // controller commands
  typedef struct packed {
    logic             load_in;
    logic             hp_rd;
    logic             hp_upd;
    logic             hp_mul;
    logic             div_start;
    logic             div_hp;
    logic             hp_fin;
    logic             lp_wr;
    logic             mac_rd;
    logic [IDX_W-1:0] mac_idx;
    logic             lp_fin;
    logic             out_load;
  } ebf_cmd_t;

  // datapath status
  typedef struct packed {
    logic ch_ok;
    logic hp_en;
    logic lp_on;
    logic lp_long;
    logic div_done;
    logic div_busy;
  } ebf_stat_t;

endpackage

// File: rtl/core/ebf_ram.sv
// ----------------------------------------------------------------------------
// ebf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ebf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ebf_div.sv
// ----------------------------------------------------------------------------
// ebf_div
// Iterative signed by unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module ebf_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [ebf_pkg::DIV_W-1:0]    dividend,
  input  logic [ebf_pkg::REG_W-1:0]           divisor,
  output logic                                busy,
  output logic                                done,
  output logic signed [ebf_pkg::DIV_W-1:0]    quotient
);

  logic [ebf_pkg::DIV_W-1:0]  q_r, q_nxt;
  logic [ebf_pkg::REG_W-1:0]  rem_r, rem_nxt;
  logic [ebf_pkg::REG_W-1:0]  den_r;
  logic                       neg_r;
  logic [ebf_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [ebf_pkg::REG_W:0]    trial;
  logic [ebf_pkg::REG_W:0]    diff;
  logic [ebf_pkg::DIV_W-1:0]  mag;

  assign mag   = dividend[ebf_pkg::DIV_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial = {rem_r, q_r[ebf_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, den_r};

  // one restoring step
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      if (!diff[ebf_pkg::REG_W]) begin
        rem_nxt = diff[ebf_pkg::REG_W-1:0];
        q_nxt   = {q_r[ebf_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[ebf_pkg::REG_W-1:0];
        q_nxt   = {q_r[ebf_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ebf_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= ebf_pkg::DCNT_W'(ebf_pkg::DIV_W);
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= mag;
      rem_r <= '0;
      den_r <= divisor;
      neg_r <= dividend[ebf_pkg::DIV_W-1];
    end else begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

// File: rtl/core/ebf_ctrl.sv
// ----------------------------------------------------------------------------
// ebf_ctrl
// Sequencer: steps one request through baseline removal, the FIR
// multiply-accumulate loop, the shared divider and the output register.
// ----------------------------------------------------------------------------
module ebf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ebf_pkg::ebf_stat_t stat,
  output ebf_pkg::ebf_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHK     = 4'd1;
  localparam logic [3:0] S_HP_RD   = 4'd2;
  localparam logic [3:0] S_HP_UPD  = 4'd3;
  localparam logic [3:0] S_HP_MUL  = 4'd4;
  localparam logic [3:0] S_HP_DIVS = 4'd5;
  localparam logic [3:0] S_HP_DIVW = 4'd6;
  localparam logic [3:0] S_HP_FIN  = 4'd7;
  localparam logic [3:0] S_LP_WR   = 4'd8;
  localparam logic [3:0] S_LP_MAC  = 4'd9;
  localparam logic [3:0] S_LP_DIVS = 4'd10;
  localparam logic [3:0] S_LP_DIVW = 4'd11;
  localparam logic [3:0] S_LP_FIN  = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0]                  state_r, state_nxt;
  logic [ebf_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                        ov_r, ov_nxt;
  logic [ebf_pkg::IDX_W-1:0]   len;

  assign len = stat.lp_long ? ebf_pkg::IDX_W'(ebf_pkg::LONG_LEN)
                            : ebf_pkg::IDX_W'(ebf_pkg::SHORT_LEN);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    cmd.mac_idx = idx_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        priority if (!stat.ch_ok) state_nxt = S_DONE;
        else if (stat.hp_en)      state_nxt = S_HP_RD;
        else if (stat.lp_on)      state_nxt = S_LP_WR;
        else                      state_nxt = S_DONE;
      end
      S_HP_RD: begin
        cmd.hp_rd = 1'b1;
        state_nxt = S_HP_UPD;
      end
      S_HP_UPD: begin
        cmd.hp_upd = 1'b1;
        state_nxt  = S_HP_MUL;
      end
      S_HP_MUL: begin
        cmd.hp_mul = 1'b1;
        state_nxt  = S_HP_DIVS;
      end
      S_HP_DIVS: begin
        cmd.div_start = 1'b1;
        cmd.div_hp    = 1'b1;
        state_nxt     = S_HP_DIVW;
      end
      S_HP_DIVW: begin
        if (stat.div_done) state_nxt = S_HP_FIN;
      end
      S_HP_FIN: begin
        cmd.hp_fin = 1'b1;
        state_nxt  = stat.lp_on ? S_LP_WR : S_DONE;
      end
      S_LP_WR: begin
        cmd.lp_wr = 1'b1;
        idx_nxt   = '0;
        state_nxt = S_LP_MAC;
      end
      // read taps, then let the multiply and accumulate stages drain
      S_LP_MAC: begin
        cmd.mac_rd = (idx_r < len);
        idx_nxt    = idx_r + 1'b1;
        if (idx_r == len + 1'b1) state_nxt = S_LP_DIVS;
      end
      S_LP_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_LP_DIVW;
      end
      S_LP_DIVW: begin
        if (stat.div_done) state_nxt = S_LP_FIN;
      end
      S_LP_FIN: begin
        cmd.lp_fin = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

endmodule

// File: rtl/core/ebf_dp.sv
// ----------------------------------------------------------------------------
// ebf_dp
// Datapath: configuration registers, per-channel ring and tap line state,
// baseline sum, FIR multiply-accumulate, shared divider and saturation.
// ----------------------------------------------------------------------------
module ebf_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [ebf_pkg::CFG_IW-1:0]           cfg_index,
  input  logic [ebf_pkg::REG_W-1:0]            cfg_wdata,
  input  logic [ebf_pkg::CH_W-1:0]             in_channel,
  input  logic signed [ebf_pkg::SAMPLE_W-1:0]  in_sample,
  output logic signed [ebf_pkg::OUT_W-1:0]     out_filtered,
  input  ebf_pkg::ebf_cmd_t                    cmd,
  output ebf_pkg::ebf_stat_t                   stat
);

  // configuration
  logic                      hp_en_r;
  logic [1:0]                lp_mode_r;
  logic [ebf_pkg::REG_W-1:0] long_div_r;
  logic [ebf_pkg::REG_W-1:0] short_div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_en_r     <= 1'b0;
      lp_mode_r   <= ebf_pkg::LP_BYPASS;
      long_div_r  <= 16'd1024;
      short_div_r <= 16'd5;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ebf_pkg::REG_HP_EN:     hp_en_r     <= cfg_wdata[0];
        ebf_pkg::REG_LP_MODE:   lp_mode_r   <= cfg_wdata[1:0];
        ebf_pkg::REG_LONG_DIV:  long_div_r  <= cfg_wdata;
        ebf_pkg::REG_SHORT_DIV: short_div_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // working request
  logic [ebf_pkg::CH_W-1:0]        ch_r;
  logic signed [ebf_pkg::OUT_W-1:0] x_r;
  logic [ebf_pkg::CH_IW-1:0]       chi;
  logic                            ch_ok;

  assign chi   = ch_r[ebf_pkg::CH_IW-1:0];
  assign ch_ok = (32'(ch_r) < ebf_pkg::CHANNELS);

  // per-channel state
  logic signed [ebf_pkg::SUM_W-1:0] sum_r    [ebf_pkg::CHANNELS];
  logic [ebf_pkg::POS_W-1:0]        pos_r    [ebf_pkg::CHANNELS];
  logic                             filled_r [ebf_pkg::CHANNELS];
  logic [ebf_pkg::HEAD_W-1:0]       head_r   [ebf_pkg::CHANNELS];
  logic [ebf_pkg::TCNT_W-1:0]       tcnt_r   [ebf_pkg::CHANNELS];

  // baseline ring
  logic [ebf_pkg::RING_AW-1:0]       ring_addr;
  logic [ebf_pkg::SAMPLE_W-1:0]      ring_rdata;
  logic signed [ebf_pkg::SAMPLE_W-1:0] old_val;
  logic signed [ebf_pkg::SUM_W-1:0]  sum_new;
  logic [ebf_pkg::CNT_W-1:0]         pos_inc;
  logic                              wrap;
  logic [ebf_pkg::CNT_W-1:0]         cnt_r;

  assign ring_addr = ebf_pkg::RING_AW'(32'(chi) * ebf_pkg::WINDOW_LEN)
                   + ebf_pkg::RING_AW'(pos_r[chi]);

  ebf_ram #(
    .WIDTH(ebf_pkg::SAMPLE_W),
    .DEPTH(ebf_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.hp_upd),
    .waddr (ring_addr),
    .wdata (x_r[ebf_pkg::SAMPLE_W-1:0]),
    .raddr (ring_addr),
    .rdata (ring_rdata)
  );

  // slot at the write position was written only once the ring has wrapped
  assign old_val = filled_r[chi] ? $signed(ring_rdata) : '0;
  assign sum_new = sum_r[chi] - ebf_pkg::SUM_W'(old_val)
                 + ebf_pkg::SUM_W'($signed(x_r[ebf_pkg::SAMPLE_W-1:0]));
  assign pos_inc = ebf_pkg::CNT_W'(pos_r[chi]) + 1'b1;
  assign wrap    = (pos_inc == ebf_pkg::CNT_W'(ebf_pkg::WINDOW_LEN));

  // baseline dividend: sample * count - sum
  logic signed [ebf_pkg::SAMPLE_W+ebf_pkg::CNT_W:0] hp_prod;
  logic signed [ebf_pkg::DIV_W-1:0]                 hpd_r;

  assign hp_prod = $signed(x_r[ebf_pkg::SAMPLE_W-1:0]) * $signed({1'b0, cnt_r});

  // tap line
  logic [ebf_pkg::HEAD_W-1:0]  head_new;
  logic [ebf_pkg::TAP_AW-1:0]  tap_base;
  logic [ebf_pkg::TAP_AW-1:0]  tap_waddr;
  logic [ebf_pkg::TAP_AW-1:0]  tap_raddr;
  logic [ebf_pkg::AGE_W-1:0]   age_diff;
  logic [ebf_pkg::AGE_W-1:0]   age_pos;
  logic [ebf_pkg::SAMPLE_W-1:0] tap_rdata;

  assign head_new  = (32'(head_r[chi]) == ebf_pkg::TAPS - 1) ? '0 : head_r[chi] + 1'b1;
  assign tap_base  = ebf_pkg::TAP_AW'(32'(chi) * ebf_pkg::TAPS);
  assign tap_waddr = tap_base + ebf_pkg::TAP_AW'(head_new);
  assign age_diff  = ebf_pkg::AGE_W'(head_r[chi]) - ebf_pkg::AGE_W'(cmd.mac_idx);
  assign age_pos   = age_diff[ebf_pkg::AGE_W-1] ? age_diff + ebf_pkg::AGE_W'(ebf_pkg::TAPS)
                                                : age_diff;
  assign tap_raddr = tap_base + ebf_pkg::TAP_AW'(age_pos);

  ebf_ram #(
    .WIDTH(ebf_pkg::SAMPLE_W),
    .DEPTH(ebf_pkg::TAP_DEPTH)
  ) u_taps (
    .clk   (clk),
    .we    (cmd.lp_wr),
    .waddr (tap_waddr),
    .wdata (x_r[ebf_pkg::SAMPLE_W-1:0]),
    .raddr (tap_raddr),
    .rdata (tap_rdata)
  );

  // multiply-accumulate pipeline
  logic                              rv_r, rok_r, pv_r;
  logic [ebf_pkg::IDX_W-1:0]         ridx_r;
  logic signed [ebf_pkg::PROD_W-1:0] prod_r;
  logic signed [ebf_pkg::DIV_W-1:0]  acc_r;
  logic                              lp_long;

  assign lp_long = (lp_mode_r == ebf_pkg::LP_LONG);

  // shared divider
  logic signed [ebf_pkg::DIV_W-1:0] div_num;
  logic [ebf_pkg::REG_W-1:0]        div_den;
  logic [ebf_pkg::REG_W-1:0]        lp_den;
  logic signed [ebf_pkg::DIV_W-1:0] div_q;
  logic                             div_busy;
  logic                             div_done;

  assign lp_den  = lp_long ? long_div_r : short_div_r;
  assign div_num = cmd.div_hp ? hpd_r : acc_r;
  assign div_den = cmd.div_hp ? ebf_pkg::REG_W'(cnt_r)
                              : ((lp_den == '0) ? 16'd1 : lp_den);

  ebf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // saturation of the quotient
  logic signed [ebf_pkg::OUT_W-1:0] hp_sat;
  logic signed [ebf_pkg::OUT_W-1:0] lp_sat;

  always_comb begin
    priority if (div_q > ebf_pkg::HP_MAX) hp_sat = ebf_pkg::HP_MAX;
    else if (div_q < ebf_pkg::HP_MIN)     hp_sat = ebf_pkg::HP_MIN;
    else                                  hp_sat = ebf_pkg::OUT_W'(div_q);
    priority if (div_q > ebf_pkg::LP_MAX) lp_sat = ebf_pkg::LP_MAX;
    else if (div_q < ebf_pkg::LP_MIN)     lp_sat = ebf_pkg::LP_MIN;
    else                                  lp_sat = ebf_pkg::OUT_W'(div_q);
  end

  // working value and baseline registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch_r <= in_channel;
      x_r  <= ebf_pkg::OUT_W'(in_sample);
    end else if (cmd.hp_fin) begin
      x_r <= hp_sat;
    end else if (cmd.lp_fin) begin
      x_r <= lp_sat;
    end
    if (cmd.hp_upd) begin
      cnt_r <= (filled_r[chi] || wrap) ? ebf_pkg::CNT_W'(ebf_pkg::WINDOW_LEN) : pos_inc;
    end
    if (cmd.hp_mul) begin
      hpd_r <= ebf_pkg::DIV_W'(hp_prod) - ebf_pkg::DIV_W'(sum_r[chi]);
    end
  end

  // per-channel state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ebf_pkg::CHANNELS; i++) begin
        sum_r[i]    <= '0;
        pos_r[i]    <= '0;
        filled_r[i] <= 1'b0;
        head_r[i]   <= '0;
        tcnt_r[i]   <= '0;
      end
    end else begin
      if (cmd.hp_upd) begin
        sum_r[chi] <= sum_new;
        pos_r[chi] <= wrap ? '0 : pos_inc[ebf_pkg::POS_W-1:0];
        if (wrap) filled_r[chi] <= 1'b1;
      end
      if (cmd.lp_wr) begin
        head_r[chi] <= head_new;
        if (32'(tcnt_r[chi]) < ebf_pkg::TAPS) tcnt_r[chi] <= tcnt_r[chi] + 1'b1;
      end
    end
  end

  // tap read, product, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      rv_r <= cmd.mac_rd;
      pv_r <= rv_r;
    end
  end

  always_ff @(posedge clk) begin
    rok_r  <= (ebf_pkg::TCNT_W'(cmd.mac_idx) < tcnt_r[chi]);
    ridx_r <= cmd.mac_idx;
    prod_r <= rok_r ? $signed(tap_rdata) * ebf_pkg::tap_coef(ridx_r, lp_long)
                    : $signed(ebf_pkg::PROD_W'(0));
    if (cmd.lp_wr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + ebf_pkg::DIV_W'(prod_r);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) out_filtered <= x_r;
  end

  assign stat.ch_ok    = ch_ok;
  assign stat.hp_en    = hp_en_r;
  assign stat.lp_on    = (lp_mode_r == ebf_pkg::LP_LONG) || (lp_mode_r == ebf_pkg::LP_SHORT);
  assign stat.lp_long  = lp_long;
  assign stat.div_done = div_done;
  assign stat.div_busy = div_busy;

endmodule

// File: rtl/core/ecg_baseline_and_fir_filter.sv
// ----------------------------------------------------------------------------
// ecg_baseline_and_fir_filter
// Multi-channel ECG filter: moving-average baseline removal followed by an
// optional 23-tap or 5-tap FIR low-pass, one result per request.
//
//   channel | direction | signals
//   in      | input     | in_valid, in_ready, in_channel, in_sample
//   out     | output    | out_valid, out_ready, out_filtered
//   cfg     | input     | cfg_wr_en, cfg_index, cfg_wdata
//
// One request at a time: a bypassed or bad-channel request skips both filters;
// baseline removal and the low-pass each add a pass through the shared divider,
// and the low-pass also adds the one-tap-per-cycle FIR loop.
// The result register lets the next request enter while a result waits.
// Reset is synchronous; no clearing pass, ring and tap line use fill state.
// ----------------------------------------------------------------------------
module ecg_baseline_and_fir_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [ebf_pkg::CFG_IW-1:0]          cfg_index,
  input  logic [ebf_pkg::REG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ebf_pkg::CH_W-1:0]            in_channel,
  input  logic signed [ebf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ebf_pkg::OUT_W-1:0]    out_filtered
);

  ebf_pkg::ebf_cmd_t  cmd;
  ebf_pkg::ebf_stat_t stat;

  // sequencer
  ebf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  ebf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_channel   (in_channel),
    .in_sample    (in_sample),
    .out_filtered (out_filtered),
    .cmd          (cmd),
    .stat         (stat)
  );

`ifndef SYNTHESIS
  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // divider never restarted while running
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  // result register loaded only when free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");
`endif

endmodule
